@@ hdl/assert_macros.svh @@
// Assertion macros shared by the trie maximum-xor block.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Checks a property on the rising clock edge. The check is suspended while reset is high.
`define ASSERT_CLK(lbl, clk, rst, prop, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) (prop)) else $error(msg);

// Checks that a condition holds on every clock edge, reset included.
`define ASSERT_ALWAYS(lbl, clk, prop, msg) \
   lbl: assert property (@(posedge clk) (prop)) else $error(msg);

`endif

@@ hdl/btmx_pkg.sv @@
// Package of the trie maximum-xor block: default sizes, codes and control types.
package btmx_pkg;

   localparam int KEY_BITS_DEF   = 32;
   localparam int NODE_COUNT_DEF = 65536;
   localparam int KEY_W          = 32;

   localparam logic ACT_INSERT = 1'b0;
   localparam logic ACT_QUERY  = 1'b1;

   typedef enum logic [2:0] {
      ST_IDLE = 3'b001,
      ST_WALK = 3'b010,
      ST_RESP = 3'b100
   } state_type;

   typedef struct packed {
      logic load;
      logic step;
      logic finish;
   } cmd_type;

   typedef struct packed {
      logic quick;
      logic last;
   } stat_type;

endpackage

@@ hdl/btmx_ram.sv @@
// Generic single-port-write, single-port-read RAM with a registered read.
module btmx_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 64
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

@@ hdl/btmx_ctrl.sv @@
// Controller state machine of the trie maximum-xor block.
`include "assert_macros.svh"
module btmx_ctrl (
   input  logic              clock,
   input  logic              reset,
   input  logic              start,
   output logic              busy,
   output logic              rsp_valid,
   input  btmx_pkg::stat_type stat,
   output btmx_pkg::cmd_type  cmd
);
   import btmx_pkg::*;

   state_type state_ff;
   state_type state_in;
   logic      accept;

   assign accept = start && !busy;

   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         ST_IDLE, ST_RESP: begin
            if (start) begin
               state_in = stat.quick ? ST_RESP : ST_WALK;
            end else begin
               state_in = ST_IDLE;
            end
         end
         ST_WALK: begin
            state_in = stat.last ? ST_RESP : ST_WALK;
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   // A new transfer may be taken while the previous result is on the strobe.
   assign busy       = (state_ff == ST_WALK);
   assign rsp_valid  = (state_ff == ST_RESP);
   assign cmd.load   = accept;
   assign cmd.step   = (state_ff == ST_WALK);
   assign cmd.finish = (state_ff == ST_WALK) && stat.last;

   `ASSERT_CLK(a_walk_entry, clock, reset, accept && !stat.quick |=> state_ff == ST_WALK, "walk not entered")
   `ASSERT_CLK(a_quick_resp, clock, reset, accept && stat.quick |=> rsp_valid, "quick result missing")
   `ASSERT_CLK(a_walk_end, clock, reset, cmd.finish |=> rsp_valid && !busy, "walk did not end in result")

endmodule

@@ hdl/btmx_dp.sv @@
// Datapath of the trie maximum-xor block: node pool, walk registers and result registers.
`include "assert_macros.svh"
module btmx_dp #(
   parameter int KEY_BITS   = btmx_pkg::KEY_BITS_DEF,
   parameter int NODE_COUNT = btmx_pkg::NODE_COUNT_DEF
) (
   input  logic                       clock,
   input  logic                       reset,
   input  logic                       req_action,
   input  logic [btmx_pkg::KEY_W-1:0] req_key,
   input  btmx_pkg::cmd_type          cmd,
   output btmx_pkg::stat_type         stat,
   output logic                       rsp_done_action,
   output logic [btmx_pkg::KEY_W-1:0] rsp_best_xor,
   output logic                       rsp_found,
   output logic                       rsp_pool_full
);
   import btmx_pkg::*;

   localparam int NODE_W  = $clog2(NODE_COUNT);
   localparam int NCNT_W  = $clog2(NODE_COUNT + 1);
   localparam int LVL_W   = $clog2(KEY_BITS);
   localparam int ENTRY_W = 2 * NODE_W;
   localparam logic [NCNT_W-1:0] POOL_LIMIT = NCNT_W'(NODE_COUNT - KEY_BITS);

   // Walk registers.
   logic [KEY_BITS-1:0]         key_ff;
   logic                        act_ff;
   logic [NODE_W-1:0]           node_ff, node_in;
   logic                        fresh_ff, fresh_in;
   logic [LVL_W-1:0]            lvl_ff;
   logic [KEY_BITS-1:0]         best_ff, best_in;

   // Pool bookkeeping; the root links live in flops so the root needs no memory entry.
   logic [NCNT_W-1:0]           nodes_used_ff;
   logic                        any_stored_ff;
   logic [1:0][NODE_W-1:0]      root_ff;

   // Result registers.
   logic                        res_action_ff;
   logic [KEY_BITS-1:0]         res_best_ff;
   logic                        res_found_ff;
   logic                        res_full_ff;

   logic [1:0][NODE_W-1:0]      links;
   logic [1:0][NODE_W-1:0]      links_upd;
   logic [ENTRY_W-1:0]          rd_data;
   logic                        kbit;
   logic [NODE_W-1:0]           child;
   logic [NODE_W-1:0]           other;
   logic [NODE_W-1:0]           new_node;
   logic                        is_insert;
   logic                        alloc;
   logic                        pool_low;
   logic                        mem_we;

   assign pool_low   = nodes_used_ff > POOL_LIMIT;
   assign stat.quick = (req_action == ACT_QUERY) ? !any_stored_ff : pool_low;
   assign stat.last  = (lvl_ff == '0);

   assign is_insert = (act_ff == ACT_INSERT);
   assign kbit      = key_ff[lvl_ff];
   assign new_node  = nodes_used_ff[NODE_W-1:0];

   // A node allocated earlier in this walk has no children yet.
   always_comb begin
      if (node_ff == '0) begin
         links = root_ff;
      end else if (fresh_ff) begin
         links = '0;
      end else begin
         links = rd_data;
      end
   end

   assign child = links[kbit];
   assign other = links[!kbit];
   assign alloc = is_insert && (child == '0);

   always_comb begin
      links_upd       = links;
      links_upd[kbit] = new_node;
   end

   always_comb begin
      node_in  = child;
      fresh_in = 1'b0;
      best_in  = best_ff;
      if (is_insert) begin
         if (alloc) begin
            node_in  = new_node;
            fresh_in = 1'b1;
         end
      end else if (other != '0) begin
         node_in = other;
         best_in = best_ff | (KEY_BITS'(1) << lvl_ff);
      end
   end

   assign mem_we = cmd.step && alloc && (node_ff != '0);

   btmx_ram #(
      .WIDTH (ENTRY_W),
      .DEPTH (NODE_COUNT)
   ) u_pool (
      .clock   (clock),
      .wr_en   (mem_we),
      .wr_addr (node_ff),
      .wr_data (links_upd),
      .rd_addr (node_in),
      .rd_data (rd_data)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         nodes_used_ff <= NCNT_W'(1);
         any_stored_ff <= 1'b0;
         root_ff       <= '0;
      end else if (cmd.step) begin
         if (alloc) begin
            nodes_used_ff <= nodes_used_ff + NCNT_W'(1);
            if (node_ff == '0) begin
               root_ff <= links_upd;
            end
         end
         if (cmd.finish && is_insert) begin
            any_stored_ff <= 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.load) begin
         key_ff   <= req_key[KEY_BITS-1:0];
         act_ff   <= req_action;
         node_ff  <= '0;
         fresh_ff <= 1'b0;
         lvl_ff   <= LVL_W'(KEY_BITS - 1);
         best_ff  <= '0;
      end else if (cmd.step) begin
         node_ff  <= node_in;
         fresh_ff <= fresh_in;
         lvl_ff   <= lvl_ff - LVL_W'(1);
         best_ff  <= best_in;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.load && stat.quick) begin
         res_action_ff <= req_action;
         res_best_ff   <= '0;
         res_found_ff  <= 1'b0;
         res_full_ff   <= (req_action == ACT_INSERT);
      end else if (cmd.finish) begin
         res_action_ff <= act_ff;
         res_best_ff   <= is_insert ? '0 : best_in;
         res_found_ff  <= !is_insert;
         res_full_ff   <= 1'b0;
      end
   end

   assign rsp_done_action = res_action_ff;
   assign rsp_best_xor    = KEY_W'(res_best_ff);
   assign rsp_found       = res_found_ff;
   assign rsp_pool_full   = res_full_ff;

   `ASSERT_CLK(a_pool_bound, clock, reset, nodes_used_ff <= NCNT_W'(NODE_COUNT), "node pool overrun")
   `ASSERT_CLK(a_no_root_write, clock, reset, mem_we |-> node_ff != '0, "memory write to root")
   `ASSERT_CLK(a_stored_set, clock, reset, cmd.finish && is_insert |=> any_stored_ff, "insert not recorded")

endmodule

@@ hdl/binary_trie_max_xor_top.sv @@
// The result strobes once the walk has stepped through every trie level; a refused insert
// or a query on an empty trie strobes in the cycle right after the accepting edge.
// No new item is taken during a walk: busy is high in every walk step.
// A new start is taken in the cycle the previous result strobes; results cannot be stalled.
// Synchronous reset empties the trie to the root node; the node pool needs no clearing pass.
module binary_trie_max_xor_top #(
   parameter int KEY_BITS   = btmx_pkg::KEY_BITS_DEF,
   parameter int NODE_COUNT = btmx_pkg::NODE_COUNT_DEF
) (
   input  logic                       clock,
   input  logic                       reset,
   input  logic                       start,
   output logic                       busy,
   input  logic                       req_action,
   input  logic [btmx_pkg::KEY_W-1:0] req_key,
   output logic                       rsp_valid,
   output logic                       rsp_done_action,
   output logic [btmx_pkg::KEY_W-1:0] rsp_best_xor,
   output logic                       rsp_found,
   output logic                       rsp_pool_full
);
   import btmx_pkg::*;

   cmd_type  cmd;
   stat_type stat;

   btmx_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .start     (start),
      .busy      (busy),
      .rsp_valid (rsp_valid),
      .stat      (stat),
      .cmd       (cmd)
   );

   btmx_dp #(
      .KEY_BITS   (KEY_BITS),
      .NODE_COUNT (NODE_COUNT)
   ) u_dp (
      .clock           (clock),
      .reset           (reset),
      .req_action      (req_action),
      .req_key         (req_key),
      .cmd             (cmd),
      .stat            (stat),
      .rsp_done_action (rsp_done_action),
      .rsp_best_xor    (rsp_best_xor),
      .rsp_found       (rsp_found),
      .rsp_pool_full   (rsp_pool_full)
   );

endmodule
